@@ rtl/core/ses_pkg.sv @@
// Package for the sampled eviction selector: policy codes, field widths,
// shared structs. No dependencies.
package ses_pkg;

   localparam int ENTRY_REF_WIDTH_DEF = 16;
   localparam int OUT_REF_WIDTH       = 16;
   localparam int CLOCK_WIDTH         = 32;
   localparam int FREQ_WIDTH          = 8;
   localparam int MINUTE_WIDTH        = 16;
   localparam int MS_WIDTH            = 48;
   localparam int RANDOM_WIDTH        = 31;
   localparam int SCORE_WIDTH         = MS_WIDTH + 1;
   localparam int DECAY_LIMIT         = 8;

   typedef enum logic [2:0] {
      POL_NONE       = 3'd0,
      POL_ALL_LRU    = 3'd1,
      POL_ALL_LFU    = 3'd2,
      POL_ALL_RANDOM = 3'd3,
      POL_VOL_LRU    = 3'd4,
      POL_VOL_LFU    = 3'd5,
      POL_VOL_RANDOM = 3'd6,
      POL_VOL_TTL    = 3'd7
   } policy_type;

   typedef logic signed [SCORE_WIDTH-1:0] score_type;

   // control of the scored stage, handed to the selector
   typedef struct packed {
      logic valid;
      logic scored;
      logic last;
   } stage_ctl_type;

endpackage

@@ rtl/core/ses_score.sv @@
// Scoring logic for one sampled word under the current eviction policy.
// Depends on ses_pkg.
module ses_score (
   input  ses_pkg::policy_type                        policy,
   input  logic [ses_pkg::CLOCK_WIDTH-1:0]            last_access_clock,
   input  logic [ses_pkg::CLOCK_WIDTH-1:0]            clock_now,
   input  logic [ses_pkg::FREQ_WIDTH-1:0]             freq_count,
   input  logic [ses_pkg::MINUTE_WIDTH-1:0]           freq_stamp_minute,
   input  logic [ses_pkg::MINUTE_WIDTH-1:0]           minute_now,
   input  logic                                       has_expiry,
   input  logic [ses_pkg::MS_WIDTH-1:0]               expire_at_ms,
   input  logic [ses_pkg::MS_WIDTH-1:0]               now_ms,
   input  logic [ses_pkg::RANDOM_WIDTH-1:0]           random_word,
   output logic                                       scored,
   output ses_pkg::score_type                         score
);
   import ses_pkg::*;

   logic [MINUTE_WIDTH-1:0] elapsed;
   logic [FREQ_WIDTH-1:0]   decayed;
   score_type               lru_score;
   score_type               lfu_score;
   score_type               ttl_score;
   score_type               rnd_score;

   assign elapsed = minute_now - freq_stamp_minute;

   // clock went back: counter left as it is
   always_comb begin
      if (minute_now < freq_stamp_minute) begin
         decayed = freq_count;
      end else if (elapsed >= MINUTE_WIDTH'(DECAY_LIMIT)) begin
         decayed = '0;
      end else begin
         decayed = freq_count >> elapsed[2:0];
      end
   end

   assign lru_score = $signed({(SCORE_WIDTH-CLOCK_WIDTH)'(0), clock_now})
                    - $signed({(SCORE_WIDTH-CLOCK_WIDTH)'(0), last_access_clock});
   assign lfu_score = -$signed({(SCORE_WIDTH-FREQ_WIDTH)'(0), decayed});
   assign ttl_score = $signed({1'b0, now_ms}) - $signed({1'b0, expire_at_ms});
   assign rnd_score = $signed({(SCORE_WIDTH-RANDOM_WIDTH)'(0), random_word});

   always_comb begin
      scored = 1'b1;
      score  = '0;
      case (policy)
         POL_ALL_LRU, POL_VOL_LRU:       score = lru_score;
         POL_ALL_LFU, POL_VOL_LFU:       score = lfu_score;
         POL_ALL_RANDOM, POL_VOL_RANDOM: score = rnd_score;
         POL_VOL_TTL:                    score = ttl_score;
         default:                        scored = 1'b0;
      endcase
      // volatile policies skip words without expiry
      if (policy[2] && !has_expiry) begin
         scored = 1'b0;
      end
   end

endmodule

@@ rtl/core/ses_select.sv @@
// Best-so-far tracker and result register of the eviction selector.
// Depends on ses_pkg.
module ses_select #(
   parameter int ENTRY_REF_WIDTH = ses_pkg::ENTRY_REF_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ses_pkg::stage_ctl_type             ctl,
   input  logic                               advance,
   input  ses_pkg::score_type                 score,
   input  logic [ENTRY_REF_WIDTH-1:0]         entry_ref,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_winner_valid,
   output logic [ses_pkg::OUT_REF_WIDTH-1:0]  rsp_winner_ref,
   output ses_pkg::score_type                 rsp_winner_score
);
   import ses_pkg::*;

   logic                       best_held_ff, best_held_in;
   score_type                  best_score_ff, best_score_in;
   logic [ENTRY_REF_WIDTH-1:0] best_ref_ff, best_ref_in;
   logic                       nxt_held;
   score_type                  nxt_score;
   logic [ENTRY_REF_WIDTH-1:0] nxt_ref;
   logic [31:0]                ref_ext;
   logic                       take;
   logic                       emit;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       win_valid_ff;
   logic [OUT_REF_WIDTH-1:0]   win_ref_ff;
   score_type                  win_score_ff;

   // only a strictly greater score replaces the held one
   assign take = ctl.valid && ctl.scored && (!best_held_ff || score > best_score_ff);

   always_comb begin
      nxt_held  = best_held_ff;
      nxt_score = best_score_ff;
      nxt_ref   = best_ref_ff;
      if (take) begin
         nxt_held  = 1'b1;
         nxt_score = score;
         nxt_ref   = entry_ref;
      end
   end

   assign emit    = advance && ctl.last;
   assign ref_ext = 32'(nxt_ref);

   always_comb begin
      best_held_in  = best_held_ff;
      best_score_in = best_score_ff;
      best_ref_in   = best_ref_ff;
      if (advance) begin
         best_held_in  = emit ? 1'b0 : nxt_held;
         best_score_in = nxt_score;
         best_ref_in   = nxt_ref;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_held_ff <= best_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_score_ff <= best_score_in;
      best_ref_ff   <= best_ref_in;
      if (emit) begin
         win_valid_ff <= nxt_held;
         win_ref_ff   <= nxt_held ? ref_ext[OUT_REF_WIDTH-1:0] : '0;
         win_score_ff <= nxt_held ? nxt_score : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_winner_valid = win_valid_ff;
   assign rsp_winner_ref   = win_ref_ff;
   assign rsp_winner_score = win_score_ff;

endmodule

@@ rtl/core/sampled_eviction_selector_core.sv @@
// Sampled eviction selector top level. A last word passes the scored stage
// register and then the result register before its result shows on the result
// port. Throughput: one word per cycle; a last word held behind a stalled
// result stalls the input. Reset (synchronous, active high) sets policy to
// none, empties the scored stage and the result register, clears the best-so-far.
// Depends on ses_pkg, ses_score, ses_select.
module sampled_eviction_selector_core #(
   parameter int ENTRY_REF_WIDTH = ses_pkg::ENTRY_REF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [2:0]                           csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ENTRY_REF_WIDTH-1:0]           req_entry_ref,
   input  logic [ses_pkg::CLOCK_WIDTH-1:0]      req_last_access_clock,
   input  logic [ses_pkg::CLOCK_WIDTH-1:0]      req_clock_now,
   input  logic [ses_pkg::FREQ_WIDTH-1:0]       req_freq_count,
   input  logic [ses_pkg::MINUTE_WIDTH-1:0]     req_freq_stamp_minute,
   input  logic [ses_pkg::MINUTE_WIDTH-1:0]     req_minute_now,
   input  logic                                 req_has_expiry,
   input  logic [ses_pkg::MS_WIDTH-1:0]         req_expire_at_ms,
   input  logic [ses_pkg::MS_WIDTH-1:0]         req_now_ms,
   input  logic [ses_pkg::RANDOM_WIDTH-1:0]     req_random_word,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_winner_valid,
   output logic [ses_pkg::OUT_REF_WIDTH-1:0]    rsp_winner_ref,
   output logic signed [ses_pkg::SCORE_WIDTH-1:0] rsp_winner_score
);
   import ses_pkg::*;

   policy_type                 policy_ff;
   logic                       scored;
   score_type                  score;
   logic                       accept;
   logic                       advance;

   stage_ctl_type              s1_ctl_ff, s1_ctl_in;
   score_type                  s1_score_ff;
   logic [ENTRY_REF_WIDTH-1:0] s1_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_NONE;
      end else if (csr_wr_en) begin
         policy_ff <= policy_type'(csr_wr_data);
      end
   end

   ses_score u_score (
      .policy            (policy_ff),
      .last_access_clock (req_last_access_clock),
      .clock_now         (req_clock_now),
      .freq_count        (req_freq_count),
      .freq_stamp_minute (req_freq_stamp_minute),
      .minute_now        (req_minute_now),
      .has_expiry        (req_has_expiry),
      .expire_at_ms      (req_expire_at_ms),
      .now_ms            (req_now_ms),
      .random_word       (req_random_word),
      .scored            (scored),
      .score             (score)
   );

   // a non-last word always moves on; a last one needs room in the result reg
   assign advance   = s1_ctl_ff.valid && (!s1_ctl_ff.last || !rsp_valid || !rsp_stall);
   assign req_stall = s1_ctl_ff.valid && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_ctl_in = s1_ctl_ff;
      if (accept) begin
         s1_ctl_in.valid  = 1'b1;
         s1_ctl_in.scored = scored;
         s1_ctl_in.last   = req_last_sample;
      end else if (advance) begin
         s1_ctl_in.valid  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_score_ff <= score;
         s1_ref_ff   <= req_entry_ref;
      end
   end

   ses_select #(
      .ENTRY_REF_WIDTH (ENTRY_REF_WIDTH)
   ) u_select (
      .clock            (clock),
      .reset            (reset),
      .ctl              (s1_ctl_ff),
      .advance          (advance),
      .score            (s1_score_ff),
      .entry_ref        (s1_ref_ff),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_winner_valid (rsp_winner_valid),
      .rsp_winner_ref   (rsp_winner_ref),
      .rsp_winner_score (rsp_winner_score)
   );

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ctl_ff.last |=> rsp_valid)
      else $error("last word advanced without a result");

   a_blocked_last_stalls: assert property (@(posedge clock) disable iff (reset)
      s1_ctl_ff.valid && s1_ctl_ff.last && rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while a last word is blocked");

   a_no_winner_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_winner_valid |-> rsp_winner_ref == '0 && rsp_winner_score == '0)
      else $error("empty result carries nonzero payload");

endmodule
